/* sv/tti_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tti_pkg: shared types and constants
// Codes and widths used by the trajectory interpolator and its divider.
// ---------------------------------------------------------------------------
package tti_pkg;
   localparam int NumJoints = 7;

   localparam logic [1:0] ModeClear    = 2'd0;
   localparam logic [1:0] ModeAppend   = 2'd1;
   localparam logic [1:0] ModeOffset   = 2'd2;
   localparam logic [1:0] ModeFraction = 2'd3;

   localparam logic [1:0] StatusOk    = 2'd0;
   localparam logic [1:0] StatusEmpty = 2'd1;
   localparam logic [1:0] StatusFull  = 2'd2;

   typedef struct packed {
      logic start;
      logic [63:0] num;
      logic [63:0] den;
   } div_req_type;
endpackage
`default_nettype wire

/* sv/tti_frac_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tti_frac_div: serial fraction divider
// Computes floor(num * 2^32 / den) for num < den, one quotient bit a cycle.
// ---------------------------------------------------------------------------
module tti_frac_div
   import tti_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output logic             done,
   output logic [31:0]      quotient
);
   logic [63:0] rem_ff, rem_in;
   logic [63:0] den_ff, den_in;
   logic [31:0] q_ff, q_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [64:0] shifted;

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      shifted = {rem_ff, 1'b0};
      if (div_req.start) begin
         rem_in  = div_req.num;
         den_in  = div_req.den;
         q_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = 64'(shifted - {1'b0, den_ff});
            q_in   = {q_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted[63:0];
            q_in   = {q_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else       busy_ff <= busy_in;
   end

   assign done     = busy_ff && (cnt_ff == 6'd31);
   assign quotient = q_in;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff <= 6'd31) else $error("divider count overrun");
   a_done_ends: assert property (@(posedge clock) disable iff (reset)
      (done && !div_req.start) |=> !busy_ff) else $error("divider did not stop");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> busy_ff) else $error("divider did not start");
endmodule
`default_nettype wire

/* sv/timestamped_trajectory_interpolator.sv */
`timescale 1ns / 1ps
`default_nettype none
// A clear, a dropped append or a query on an empty table goes straight to the response. An
// append writes one joint a cycle, the time with the first, and a query at or beyond either end
// skips the search and the divider. An interior query takes S <= ceil(log2 of the sample count)
// binary search steps, a serial divider for the weight, and seven joints blended in turn on one
// shared 32x32 multiplier. One transaction at a time; synchronous active-high reset empties the
// table, but the stores themselves are not cleared.
// ---------------------------------------------------------------------------
// timestamped_trajectory_interpolator
// Timestamped seven-joint sample table with piecewise linear lookup.
// ---------------------------------------------------------------------------
module timestamped_trajectory_interpolator
   import tti_pkg::*;
#(
   parameter int MAX_SAMPLES = 1024
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // tdata from bit 0: mode[2], sample_time_ns[64], joint0..joint6[32 each],
   // query_offset_ns[64], play_fraction[17], zero pad to 376 bits
   input  wire logic [375:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // tdata from bit 0: status[2], out_joint0..out_joint6[32 each], pad to 232
   output logic [231:0]      rsp_tdata
);
   localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam int JW = $clog2(MAX_SAMPLES * NumJoints);

   // Sequencer states.
   localparam logic [4:0] S_IDLE = 5'd0, S_DEC = 5'd1, S_APP = 5'd2,
      S_RDFL = 5'd3, S_WTF = 5'd4, S_WTL = 5'd5, S_PLAN = 5'd6,
      S_SRCH = 5'd7, S_SCMP = 5'd8, S_RDLO = 5'd9, S_RDHI = 5'd10,
      S_WHI = 5'd11, S_DIV = 5'd12, S_JRD = 5'd13, S_JMUL = 5'd14,
      S_OUT = 5'd15, S_CHK = 5'd16;

   // Memories: time entries and joint entries, one access per cycle each.
   logic [63:0] tmem [MAX_SAMPLES];
   logic [31:0] jmem [MAX_SAMPLES * NumJoints];
   logic [63:0] trd_ff;
   logic [31:0] jrd_ff;
   logic        twe, jwe;
   logic [AW-1:0] taddr;
   logic [JW-1:0] jaddr;
   logic [63:0] twdata;
   logic [31:0] jwdata;

   always_ff @(posedge clock) begin
      if (twe) tmem[taddr] <= twdata;
      trd_ff <= tmem[taddr];
   end
   always_ff @(posedge clock) begin
      if (jwe) jmem[jaddr] <= jwdata;
      jrd_ff <= jmem[jaddr];
   end

   logic [4:0]    st_ff, st_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [375:0]  req_ff, req_in;
   logic [63:0]   first_ff, first_in, last_ff, last_in, off_ff, off_in;
   logic [63:0]   span_ff, span_in;
   logic [63:0]   rlo_ff, rlo_in;
   logic [CW-1:0] a_ff, a_in, b_ff, b_in;
   logic [AW-1:0] row_ff, row_in;
   logic [2:0]    j_ff, j_in;
   logic [31:0]   alpha_ff, alpha_in, ql_ff, ql_in;
   logic [31:0]   mag_ff, mag_in;
   logic          neg_ff, neg_in;
   logic [1:0]    status_ff, status_in;
   logic [31:0]   oj_ff [NumJoints];
   logic [31:0]   ojv;
   logic          ojwe;
   logic          rv_ff, rv_in;
   logic [AW-1:0] lo_ff, lo_in;
   div_req_type   dreq;
   logic          ddone;
   logic [31:0]   dq;

   tti_frac_div u_div (.clock(clock), .reset(reset), .div_req(dreq),
      .done(ddone), .quotient(dq));

   wire [1:0]  r_mode = req_ff[1:0];
   wire [63:0] r_time = req_ff[65:2];
   wire [63:0] r_qoff = req_ff[353:290];
   wire [16:0] r_frac = req_ff[370:354];
   wire [CW-1:0] mid  = CW'(a_ff + ((b_ff - a_ff) >> 1));

   // Joint difference magnitude and the shared multiplier.
   logic [31:0] mag;
   logic [63:0] prod;
   logic [16:0] fsat;
   logic signed [32:0] dsx;
   always_comb begin
      fsat = (r_frac > 17'd65536) ? 17'd65536 : r_frac;
      dsx  = $signed({jrd_ff[31], jrd_ff}) - $signed({ql_ff[31], ql_ff});
      mag  = dsx[32] ? 32'(-dsx) : 32'(dsx);
      prod = mag_ff * alpha_ff;
   end
   // The upper operand bits are zero, so this is a 48 by 17 bit product, and
   // with the fraction at most 65536 it never exceeds 64 bits.
   wire [63:0] frac_hi  = {16'd0, span_ff[63:16]} * {47'd0, fsat};
   wire [32:0] frac_lo  = span_ff[15:0] * fsat;
   wire [63:0] frac_off = frac_hi + {47'd0, frac_lo[32:16]};
   wire [31:0] pj = prod[63:32];
   wire [31:0] blend = neg_ff ? (ql_ff - pj) : (ql_ff + pj);

   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; req_in = req_ff;
      first_in = first_ff; last_in = last_ff; off_in = off_ff; span_in = span_ff;
      rlo_in = rlo_ff; a_in = a_ff; b_in = b_ff; row_in = row_ff;
      j_in = j_ff; alpha_in = alpha_ff; ql_in = ql_ff; mag_in = mag_ff; neg_in = neg_ff;
      status_in = status_ff; rv_in = rv_ff; lo_in = lo_ff;
      twe = 1'b0; jwe = 1'b0; taddr = '0; jaddr = '0;
      twdata = r_time; jwdata = req_ff[66 + 32*j_ff +: 32];
      ojwe = 1'b0; ojv = '0;
      dreq.start = 1'b0; dreq.num = off_ff - rlo_ff; dreq.den = trd_ff - first_ff - rlo_ff;
      unique case (st_ff)
         S_IDLE: if (req_tvalid) begin
            req_in = req_tdata; st_in = S_DEC;
         end
         S_DEC: begin
            status_in = StatusOk; j_in = '0;
            unique case (r_mode)
               ModeClear: begin cnt_in = '0; st_in = S_OUT; end
               ModeAppend: begin
                  if (cnt_ff >= CW'(MAX_SAMPLES)) begin
                     status_in = StatusFull; st_in = S_OUT;
                  end else begin
                     if (cnt_ff != '0 && $signed(r_time) < $signed(last_ff))
                        req_in[65:2] = last_ff;
                     st_in = S_APP;
                  end
               end
               default: begin
                  if (cnt_ff == '0) begin
                     status_in = StatusEmpty; st_in = S_OUT;
                  end else begin
                     span_in = last_ff - first_ff; st_in = S_PLAN;
                  end
               end
            endcase
            ojwe = 1'b1;
         end
         S_APP: begin
            jwe = 1'b1;
            jaddr = JW'(cnt_ff[AW-1:0] * NumJoints) + JW'(j_ff);
            if (j_ff == 3'd0) begin
               twe = 1'b1; taddr = cnt_ff[AW-1:0];
               if (cnt_ff == '0) first_in = r_time;
               last_in = r_time;
            end
            j_in = j_ff + 3'd1;
            if (j_ff == 3'(NumJoints - 1)) begin
               cnt_in = cnt_ff + CW'(1); st_in = S_OUT;
            end
         end
         S_PLAN: begin
            // The playback offset is registered before it is compared.
            if (r_mode == ModeOffset) off_in = r_qoff; else off_in = frac_off;
            st_in = S_CHK;
         end
         S_CHK: begin
            if (off_ff == '0 || (r_mode == ModeOffset && off_ff[63])) begin
               row_in = '0; alpha_in = '0; lo_in = '0; st_in = S_RDLO;
            end else if (off_ff >= span_ff) begin
               row_in = AW'(cnt_ff - CW'(1)); lo_in = AW'(cnt_ff - CW'(1));
               alpha_in = '0; st_in = S_RDLO;
            end else begin
               a_in = '0; b_in = cnt_ff - CW'(1); st_in = S_SRCH;
            end
         end
         S_SRCH: begin
            if (a_ff < b_ff) begin
               taddr = mid[AW-1:0]; st_in = S_SCMP;
            end else begin
               row_in = (a_ff == '0) ? AW'(1) : AW'(a_ff);
               lo_in  = AW'(row_in - AW'(1));
               taddr  = lo_in; st_in = S_RDFL;
            end
         end
         S_SCMP: begin
            if (trd_ff - first_ff > off_ff) b_in = mid; else a_in = mid + CW'(1);
            st_in = S_SRCH;
         end
         S_RDFL: begin
            taddr = row_ff; rlo_in = trd_ff - first_ff; st_in = S_WTL;
         end
         S_WTL: begin
            // trd_ff holds the upper bracket time here.
            if ((trd_ff - first_ff) > rlo_ff && off_ff >= rlo_ff
                  && (off_ff - rlo_ff) < (trd_ff - first_ff - rlo_ff)) begin
               dreq.start = 1'b1; st_in = S_DIV;
            end else begin
               alpha_in = '0; st_in = S_RDLO;
            end
         end
         S_DIV: if (ddone) begin alpha_in = dq; st_in = S_RDLO; end
         S_RDLO: begin
            jaddr = JW'(lo_ff * NumJoints) + JW'(j_ff); st_in = S_WTF;
         end
         S_WTF: begin
            // jrd_ff holds the lower bracket joint here.
            ql_in = jrd_ff;
            jaddr = JW'(row_ff * NumJoints) + JW'(j_ff); st_in = S_RDHI;
         end
         S_RDHI: begin
            // jrd_ff holds the upper bracket joint here.
            mag_in = mag; neg_in = dsx[32]; st_in = S_JMUL;
         end
         S_JMUL: begin
            ojwe = 1'b1; ojv = blend; j_in = j_ff + 3'd1;
            st_in = (j_ff == 3'(NumJoints - 1)) ? S_OUT : S_RDLO;
         end
         S_OUT: begin
            rv_in = 1'b1; st_in = S_WHI;
         end
         S_WHI: if (rv_ff && rsp_tready) begin rv_in = 1'b0; st_in = S_IDLE; end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in; first_ff <= first_in; last_ff <= last_in;
      off_ff <= off_in; span_ff <= span_in; rlo_ff <= rlo_in; a_ff <= a_in; b_ff <= b_in;
      row_ff <= row_in; j_ff <= j_in; alpha_ff <= alpha_in; ql_ff <= ql_in;
      mag_ff <= mag_in; neg_ff <= neg_in;
      status_ff <= status_in; lo_ff <= lo_in;
      if (ojwe) begin
         if (st_ff == S_DEC) begin
            for (int k = 0; k < NumJoints; k++) oj_ff[k] <= '0;
         end else oj_ff[j_ff] <= ojv;
      end
      if (reset) begin
         st_ff <= S_IDLE; cnt_ff <= '0; rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; rv_ff <= rv_in;
      end
   end

   assign req_tready = (st_ff == S_IDLE);
   assign rsp_tvalid = rv_ff;
   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[1:0] = status_ff;
      for (int k = 0; k < NumJoints; k++) rsp_tdata[2 + 32*k +: 32] = oj_ff[k];
   end

   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_SAMPLES)) else $error("sample count overflow");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid) else $error("response dropped");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("accept while response pending");
endmodule
`default_nettype wire
